// File: design/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// types and constants shared by the septet unpacker modules
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int ByteWidth   = 8;
    localparam int SeptetWidth = 7;
    localparam int CountWidth  = 10;
    localparam int PhaseWidth  = 3;
    localparam int CarryWidth  = 6;

    localparam int MaxSeptets  = 1023;

    localparam logic [PhaseWidth-1:0] FirstPhase = 3'd1;
    localparam logic [PhaseWidth-1:0] LastPhase  = 3'd7;

    localparam int ResultDepth = 4;
    localparam int PtrWidth    = $clog2(ResultDepth);
    localparam int LevelWidth  = $clog2(ResultDepth + 1);

    typedef struct packed {
        logic [ByteWidth-1:0]  packed_byte;
        logic                  start_of_message;
        logic [CountWidth-1:0] septet_count;
    } in_item_t;

    typedef struct packed {
        logic [SeptetWidth-1:0] septet;
        logic                   last_of_item;
        logic                   end_of_message;
    } out_item_t;

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

// File: design/psu_unpack.sv
// ----------------------------------------------------------------------------
// psu_unpack
// input register, message state, septet extraction: one byte per cycle if room
// ----------------------------------------------------------------------------
module psu_unpack #(
    parameter int MAX_SEPTETS = psu_pkg::MaxSeptets
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  psu_pkg::in_item_t   item,
    input  logic                room,
    output psu_pkg::push_t      push,
    output psu_pkg::out_item_t  result_first,
    output psu_pkg::out_item_t  result_second
);

    logic                                in_valid_reg;
    logic                                in_valid_next;
    psu_pkg::in_item_t                   in_reg;
    logic [psu_pkg::PhaseWidth-1:0]      phase_reg;
    logic [psu_pkg::PhaseWidth-1:0]      phase_next;
    logic [psu_pkg::CarryWidth-1:0]      carry_reg;
    logic [psu_pkg::CarryWidth-1:0]      carry_next;
    logic [psu_pkg::CountWidth-1:0]      done_reg;
    logic [psu_pkg::CountWidth-1:0]      done_next;
    logic [psu_pkg::CountWidth-1:0]      target_reg;
    logic [psu_pkg::CountWidth-1:0]      target_next;

    logic                                consume;
    logic [psu_pkg::PhaseWidth-1:0]      phase_eff;
    logic [psu_pkg::CarryWidth-1:0]      carry_eff;
    logic [psu_pkg::CountWidth-1:0]      done_eff;
    logic [psu_pkg::CountWidth-1:0]      target_eff;
    logic [psu_pkg::CountWidth-1:0]      done_one;
    logic [psu_pkg::CountWidth-1:0]      done_two;
    logic                                active;
    logic                                reached_one;
    logic [13:0]                         carry_shift;
    logic [psu_pkg::ByteWidth-1:0]       byte_shift;
    logic [psu_pkg::ByteWidth-1:0]       low_mask;
    logic [psu_pkg::SeptetWidth-1:0]     septet_val;

    assign consume    = in_valid_reg && room;
    assign item_ready = !in_valid_reg || consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && item_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    // start of message overrides the held state before the byte is used
    always_comb
    begin
        phase_eff  = phase_reg;
        carry_eff  = carry_reg;
        done_eff   = done_reg;
        target_eff = target_reg;
        if (in_reg.start_of_message)
        begin
            phase_eff = psu_pkg::FirstPhase;
            carry_eff = '0;
            done_eff  = '0;
            if (int'(in_reg.septet_count) > MAX_SEPTETS)
            begin
                target_eff = psu_pkg::CountWidth'(MAX_SEPTETS);
            end
            else
            begin
                target_eff = in_reg.septet_count;
            end
        end
    end

    assign active      = done_eff < target_eff;
    assign done_one    = done_eff + psu_pkg::CountWidth'(1);
    assign done_two    = done_one + psu_pkg::CountWidth'(1);
    assign reached_one = done_one >= target_eff;

    assign carry_shift = 14'(carry_eff) << (4'd8 - {1'b0, phase_eff});
    assign byte_shift  = in_reg.packed_byte >> phase_eff;
    assign low_mask    = 8'((9'd1 << phase_eff) - 9'd1);
    assign septet_val  = carry_shift[psu_pkg::SeptetWidth-1:0]
                       | byte_shift[psu_pkg::SeptetWidth-1:0];

    always_comb
    begin
        phase_next    = phase_eff;
        carry_next    = carry_eff;
        done_next     = done_eff;
        target_next   = target_eff;
        push          = '0;
        result_first  = '{septet: septet_val, last_of_item: 1'b1, end_of_message: reached_one};
        result_second = '{septet: in_reg.packed_byte[psu_pkg::SeptetWidth-1:0],
                          last_of_item: 1'b1,
                          end_of_message: done_two >= target_eff};
        if (active)
        begin
            push.first = 1'b1;
            if (phase_eff == psu_pkg::LastPhase)
            begin
                result_first.last_of_item = reached_one;
                push.second               = !reached_one;
                done_next                 = reached_one ? done_one : done_two;
                carry_next                = '0;
                phase_next                = psu_pkg::FirstPhase;
            end
            else
            begin
                done_next  = done_one;
                carry_next = psu_pkg::CarryWidth'(in_reg.packed_byte & low_mask);
                phase_next = phase_eff + psu_pkg::PhaseWidth'(1);
            end
        end
        if (!consume)
        begin
            push = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= psu_pkg::FirstPhase;
            carry_reg    <= '0;
            done_reg     <= '0;
            target_reg   <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (consume)
            begin
                phase_reg  <= phase_next;
                carry_reg  <= carry_next;
                done_reg   <= done_next;
                target_reg <= target_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_reg <= item;
        end
    end

endmodule

// File: design/psu_result_queue.sv
// ----------------------------------------------------------------------------
// psu_result_queue
// small result queue taking up to two results per cycle, giving one
// ----------------------------------------------------------------------------
module psu_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  psu_pkg::push_t      push,
    input  psu_pkg::out_item_t  result_first,
    input  psu_pkg::out_item_t  result_second,
    output logic                room,
    output logic                result_valid,
    input  logic                result_ready,
    output psu_pkg::out_item_t  result
);

    psu_pkg::out_item_t                  entry_reg [psu_pkg::ResultDepth];
    logic [psu_pkg::PtrWidth-1:0]        head_reg;
    logic [psu_pkg::PtrWidth-1:0]        head_next;
    logic [psu_pkg::PtrWidth-1:0]        tail_reg;
    logic [psu_pkg::PtrWidth-1:0]        tail_next;
    logic [psu_pkg::PtrWidth-1:0]        tail_plus;
    logic [psu_pkg::LevelWidth-1:0]      level_reg;
    logic [psu_pkg::LevelWidth-1:0]      level_next;
    logic                                pop;
    logic [psu_pkg::LevelWidth-1:0]      push_count;

    assign result_valid = level_reg != '0;
    assign result       = entry_reg[head_reg];
    assign pop          = result_valid && result_ready;
    assign room         = level_reg <= psu_pkg::LevelWidth'(psu_pkg::ResultDepth - 2);
    assign tail_plus    = tail_reg + psu_pkg::PtrWidth'(1);
    assign push_count   = psu_pkg::LevelWidth'(push.first) + psu_pkg::LevelWidth'(push.second);

    always_comb
    begin
        head_next  = pop ? head_reg + psu_pkg::PtrWidth'(1) : head_reg;
        tail_next  = tail_reg + psu_pkg::PtrWidth'(push_count);
        level_next = level_reg + push_count - psu_pkg::LevelWidth'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            entry_reg[tail_reg] <= result_first;
        end
        if (push.second)
        begin
            entry_reg[tail_plus] <= result_second;
        end
    end

endmodule

// File: design/packed_septet_unpacker_top.sv
// ----------------------------------------------------------------------------
// packed_septet_unpacker_top
// unpacks msb-first packed 7-bit characters, one septet per result
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the four-entry result queue has room for
// two results; a byte's septets pass through the input register and the
// result queue on the way to the result port. Every seventh byte of a message
// gives two septets through the single port, so input can stall even with the
// result side always ready. Bytes outside an active message give no result.
module packed_septet_unpacker_top #(
    parameter int MAX_SEPTETS = psu_pkg::MaxSeptets
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  psu_pkg::in_item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output psu_pkg::out_item_t  result
);

    logic               room;
    psu_pkg::push_t     push;
    psu_pkg::out_item_t result_first;
    psu_pkg::out_item_t result_second;

    psu_unpack #(
        .MAX_SEPTETS (MAX_SEPTETS)
    ) u_unpack (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .room          (room),
        .push          (push),
        .result_first  (result_first),
        .result_second (result_second)
    );

    psu_result_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .result_first  (result_first),
        .result_second (result_second),
        .room          (room),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

endmodule

// File: design/psu_checker.sv
// ----------------------------------------------------------------------------
// psu_checker
// port-level checks for the septet unpacker, bound to the top level
// ----------------------------------------------------------------------------
module psu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input psu_pkg::in_item_t  item,
    input logic               result_valid,
    input logic               result_ready,
    input psu_pkg::out_item_t result
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a message can only end on the last result of a byte
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.end_of_message |-> result.last_of_item)
        else $error("end of message without last of item");

    // second septet of a byte follows at once
    a_second_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last_of_item |=> result_valid)
        else $error("second septet missing");

    // a result only appears after a byte has passed the input register and the queue
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without a byte");

    // idle result side never blocks input
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty result side");

endmodule

bind packed_septet_unpacker_top psu_checker u_psu_checker (.*);
